>>> hw/rtl/b7s_pkg.sv
// b7s_pkg: shared constants and the digit to segment lookup for the
// six-digit seven-segment encoder. no dependencies.
`timescale 1ns / 1ps

package b7s_pkg;

  localparam int unsigned ValueWidth  = 24;
  localparam int unsigned ClampWidth  = 20;
  localparam int unsigned PartWidth   = 10;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned SegWidth    = 8;

  localparam logic [ValueWidth-1:0] DisplayMax = 24'd999999;

  // reciprocal of 1000 scaled by 2^30, exact for every value up to DisplayMax
  localparam logic [40:0] RecipThousand = 41'd1073742;
  localparam int unsigned RecipShift    = 30;

  typedef logic [SegWidth-1:0]   seg_t;
  typedef logic [DigitWidth-1:0] digit_t;

  // board segment encoding, digits zero to nine
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h12;
      4'd1:    s = 8'hDB;
      4'd2:    s = 8'h86;
      4'd3:    s = 8'h83;
      4'd4:    s = 8'h4B;
      4'd5:    s = 8'h23;
      4'd6:    s = 8'h22;
      4'd7:    s = 8'h9B;
      4'd8:    s = 8'h02;
      4'd9:    s = 8'h03;
      default: s = 8'h03;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/b7s_split3.sv
// b7s_split3: splits a value below one thousand into three decimal digits
// and maps each to its segment pattern, two register stages. uses b7s_pkg.
`timescale 1ns / 1ps

module b7s_split3 (
  input  logic                              clk,
  input  logic [b7s_pkg::PartWidth-1:0]     x,
  output b7s_pkg::seg_t                     seg_lo,
  output b7s_pkg::seg_t                     seg_mid,
  output b7s_pkg::seg_t                     seg_hi
);

  logic [b7s_pkg::PartWidth-1:0] x_q;
  logic [6:0]                    div10;
  logic [b7s_pkg::DigitWidth-1:0] div100;

  logic [17:0] prod10;
  logic [22:0] prod100;
  logic [9:0]  units_wide;
  logic [6:0]  tens_wide;

  // x/10 as x*205 >> 11 and x/100 as x*5243 >> 19, exact below one thousand
  assign prod10  = {8'b0, x} * 18'd205;
  assign prod100 = {13'b0, x} * 23'd5243;

  always_ff @(posedge clk) begin
    x_q    <= x;
    div10  <= prod10[17:11];
    div100 <= prod100[22:19];
  end

  assign units_wide = x_q - ({3'b0, div10} * 10'd10);
  assign tens_wide  = div10 - ({3'b0, div100} * 7'd10);

  always_ff @(posedge clk) begin
    seg_lo  <= b7s_pkg::seg_of(units_wide[b7s_pkg::DigitWidth-1:0]);
    seg_mid <= b7s_pkg::seg_of(tens_wide[b7s_pkg::DigitWidth-1:0]);
    seg_hi  <= b7s_pkg::seg_of(div100);
  end

endmodule

>>> hw/rtl/binary_to_seven_segment_digits_core.sv
// binary_to_seven_segment_digits_core: top level of the six-digit encoder.
// uses b7s_pkg and b7s_split3.
`timescale 1ns / 1ps

// Converts an unsigned 24-bit value into six seven-segment patterns,
// units up to hundred-thousands, in the board's own segment encoding.
// Values above 999999 are clamped to 999999 and overflow is raised.
//
// Input: drive value and pulse start; a transaction is taken on every
// rising edge with start high and busy low. busy is always low, so a new
// value may be presented every cycle.
// Output: done is high for exactly one cycle with the six patterns and
// overflow; the receiver must take them in that cycle.
//
// Throughput is one transaction per cycle. The path is an input register,
// a reciprocal multiply by 1/1000, a remainder stage, then two stages per
// three-digit half (divide by 10 and 100, then digit extraction and
// table lookup into the output register).
// Reset clears the valid pipeline only; results in flight are dropped.
module binary_to_seven_segment_digits_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [b7s_pkg::ValueWidth-1:0]     value,
  output logic                               done,
  output logic [b7s_pkg::SegWidth-1:0]       seg_units,
  output logic [b7s_pkg::SegWidth-1:0]       seg_tens,
  output logic [b7s_pkg::SegWidth-1:0]       seg_hundreds,
  output logic [b7s_pkg::SegWidth-1:0]       seg_thousands,
  output logic [b7s_pkg::SegWidth-1:0]       seg_ten_thousands,
  output logic [b7s_pkg::SegWidth-1:0]       seg_hundred_thousands,
  output logic                               overflow
);

  logic [4:0] vld;

  logic [b7s_pkg::ValueWidth-1:0] in_value;

  logic [b7s_pkg::ClampWidth-1:0] clamp_value;
  logic                           clamp_ovf;
  logic [40:0]                    prod;

  logic [b7s_pkg::ClampWidth-1:0] s1_value;
  logic [b7s_pkg::PartWidth-1:0]  s1_quot;
  logic                           s1_ovf;

  logic [b7s_pkg::ClampWidth-1:0] rem_wide;
  logic [b7s_pkg::PartWidth-1:0]  s2_quot;
  logic [b7s_pkg::PartWidth-1:0]  s2_rem;
  logic                           s2_ovf;
  logic                           s3_ovf;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    in_value <= value;
  end

  always_comb begin
    clamp_ovf   = (in_value > b7s_pkg::DisplayMax);
    clamp_value = clamp_ovf ? b7s_pkg::DisplayMax[b7s_pkg::ClampWidth-1:0]
                            : in_value[b7s_pkg::ClampWidth-1:0];
    prod        = {21'b0, clamp_value} * b7s_pkg::RecipThousand;
  end

  // upper half of the number is value / 1000, below one thousand
  always_ff @(posedge clk) begin
    s1_value <= clamp_value;
    s1_quot  <= prod[b7s_pkg::RecipShift +: b7s_pkg::PartWidth];
    s1_ovf   <= clamp_ovf;
  end

  assign rem_wide = s1_value - ({10'b0, s1_quot} * 20'd1000);

  always_ff @(posedge clk) begin
    s2_quot <= s1_quot;
    s2_rem  <= rem_wide[b7s_pkg::PartWidth-1:0];
    s2_ovf  <= s1_ovf;
    s3_ovf  <= s2_ovf;
    overflow <= s3_ovf;
  end

  b7s_split3 u_low (
    .clk     (clk),
    .x       (s2_rem),
    .seg_lo  (seg_units),
    .seg_mid (seg_tens),
    .seg_hi  (seg_hundreds)
  );

  b7s_split3 u_high (
    .clk     (clk),
    .x       (s2_quot),
    .seg_lo  (seg_thousands),
    .seg_mid (seg_ten_thousands),
    .seg_hi  (seg_hundred_thousands)
  );

  assign done = vld[4];

endmodule

>>> verif/binary_to_seven_segment_digits_core_tb.sv
// binary_to_seven_segment_digits_core_tb: self-checking bench for the six-digit
// seven-segment encoder. depends on b7s_pkg and binary_to_seven_segment_digits_core.
`timescale 1ns / 1ps

module binary_to_seven_segment_digits_core_tb;

  localparam int unsigned NumRandom  = 1430;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxShown   = 999999;

  typedef logic [b7s_pkg::ValueWidth-1:0] value_t;

  typedef struct {
    value_t      value;
    int unsigned gap_pct;
  } pending_value_t;

  typedef struct {
    b7s_pkg::seg_t units;
    b7s_pkg::seg_t tens;
    b7s_pkg::seg_t hundreds;
    b7s_pkg::seg_t thousands;
    b7s_pkg::seg_t ten_thousands;
    b7s_pkg::seg_t hundred_thousands;
    logic          overflow;
  } display_t;

  // board encoding of the digits zero to nine
  localparam b7s_pkg::seg_t DigitSegs [10] = '{
    8'h12, 8'hDB, 8'h86, 8'h83, 8'h4B, 8'h23, 8'h22, 8'h9B, 8'h02, 8'h03
  };

  logic          clk;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  value_t        value = '0;
  logic          done;
  b7s_pkg::seg_t seg_units;
  b7s_pkg::seg_t seg_tens;
  b7s_pkg::seg_t seg_hundreds;
  b7s_pkg::seg_t seg_thousands;
  b7s_pkg::seg_t seg_ten_thousands;
  b7s_pkg::seg_t seg_hundred_thousands;
  logic          overflow;

  pending_value_t pending_values[$];
  display_t       expected_displays[$];
  int unsigned    total_values;
  int unsigned    accepted_values;
  int unsigned    checked_displays;
  int unsigned    clamped_values;
  int unsigned    mismatches;
  int unsigned    cycles = 0;

  binary_to_seven_segment_digits_core i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .value                 (value),
    .done                  (done),
    .seg_units             (seg_units),
    .seg_tens              (seg_tens),
    .seg_hundreds          (seg_hundreds),
    .seg_thousands         (seg_thousands),
    .seg_ten_thousands     (seg_ten_thousands),
    .seg_hundred_thousands (seg_hundred_thousands),
    .overflow              (overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic display_t predict_segments(input value_t v);
    display_t    d;
    int unsigned n;
    d.overflow = (v > MaxShown);
    n = d.overflow ? MaxShown : int'(v);
    d.units             = DigitSegs[n % 10];
    d.tens              = DigitSegs[(n / 10) % 10];
    d.hundreds          = DigitSegs[(n / 100) % 10];
    d.thousands         = DigitSegs[(n / 1000) % 10];
    d.ten_thousands     = DigitSegs[(n / 10000) % 10];
    d.hundred_thousands = DigitSegs[(n / 100000) % 10];
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  task automatic queue_value(input value_t v, input int unsigned pct);
    pending_values.push_back('{value: v, gap_pct: pct});
    total_values++;
  endtask

  // driver: take a transaction when it is accepted, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      value <= '0;
    end else begin
      if (start && !busy) begin
        expected_displays.push_back(predict_segments(value));
        accepted_values++;
        if (value > MaxShown) clamped_values++;
      end
      if (start && busy) begin
        // hold the transaction until it is taken
      end else if (pending_values.size() > 0 &&
                   $urandom_range(0, 99) >= pending_values[0].gap_pct) begin
        start <= 1'b1;
        value <= pending_values[0].value;
        void'(pending_values.pop_front());
      end else begin
        start <= 1'b0;
        value <= value_t'($urandom);
      end
    end
  end

  // monitor: every done cycle is checked against the oldest expectation
  always @(posedge clk) begin
    display_t exp_d;
    if (!rst && done) begin
      if (expected_displays.size() == 0) begin
        $display("[%0t] result with no transaction outstanding", $time);
        mismatches++;
      end else begin
        exp_d = expected_displays.pop_front();
        compare_field("seg_units", seg_units, exp_d.units);
        compare_field("seg_tens", seg_tens, exp_d.tens);
        compare_field("seg_hundreds", seg_hundreds, exp_d.hundreds);
        compare_field("seg_thousands", seg_thousands, exp_d.thousands);
        compare_field("seg_ten_thousands", seg_ten_thousands, exp_d.ten_thousands);
        compare_field("seg_hundred_thousands", seg_hundred_thousands,
                      exp_d.hundred_thousands);
        compare_field("overflow", 8'(overflow), 8'(exp_d.overflow));
        checked_displays++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    value_t      directed[$];
    int unsigned sender_pct;
    int unsigned sel;
    value_t      v;
    total_values = 0;
    accepted_values = 0;
    checked_displays = 0;
    clamped_values = 0;
    mismatches = 0;

    // digit boundaries, the clamp edge and all-ones / alternating bit patterns
    directed = '{24'd0, 24'd1, 24'd9, 24'd10, 24'd99, 24'd100, 24'd999, 24'd1000,
                 24'd9999, 24'd10000, 24'd99999, 24'd100000, 24'd123456, 24'd654321,
                 24'd987654, 24'd102030, 24'd909090, 24'd999998, 24'd999999,
                 24'd1000000, 24'h555555, 24'hAAAAAA, 24'h800000, 24'hFFFFFF};
    foreach (directed[i]) queue_value(directed[i], 30);

    // sender idles 30 percent, then 66 percent, then never
    for (int unsigned i = 0; i < NumRandom; i++) begin
      sender_pct = (i < NumRandom / 3) ? 30 : (i < 2 * NumRandom / 3) ? 66 : 0;
      sel = $urandom_range(0, 99);
      if (sel < 60)      v = value_t'($urandom_range(0, MaxShown));
      else if (sel < 70) v = value_t'($urandom_range(0, 999));
      else if (sel < 78) v = value_t'($urandom_range(MaxShown - 20, MaxShown + 20));
      else               v = value_t'($urandom);
      queue_value(v, sender_pct);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_values < total_values || expected_displays.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (expected_displays.size() > 0) begin
      $display("%0d results never arrived", expected_displays.size());
      mismatches += expected_displays.size();
    end

    $display("converted %0d values (%0d clamped above the display range), %0d results checked",
             accepted_values, clamped_values, checked_displays);
    $display("sender gaps of 30, 66 and 0 percent; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/b7s_pkg.sv
hw/rtl/b7s_split3.sv
hw/rtl/binary_to_seven_segment_digits_core.sv
verif/binary_to_seven_segment_digits_core_tb.sv
